### rtl/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg: shared definitions for the binary to decimal ASCII converter
// Widths, digit count, the ASCII offset and the control codes that the
// sequencer hands to the row of BCD digit cells.
// ----------------------------------------------------------------------------
package b2da_pkg;

   localparam int VALUE_WIDTH = 64;
   localparam int NUM_DIGITS  = 20;
   localparam int DIGIT_WIDTH = 4;
   localparam int CHAR_WIDTH  = 6;
   localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);

   // ASCII '0' reduced to the six bits of the character port.
   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = 6'h30;

   typedef enum logic [1:0] {
      MODE_HOLD,
      MODE_CLEAR,
      MODE_DABBLE,
      MODE_SHIFT
   } cell_mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

endpackage

### rtl/b2da_cell.sv
// ----------------------------------------------------------------------------
// b2da_cell: one BCD digit of the double dabble row
// Holds one decimal digit. In dabble mode it adds three when the digit is
// five or more and shifts one bit in from its lower neighbor; in shift mode
// it takes the whole digit of its lower neighbor.
// ----------------------------------------------------------------------------
module b2da_cell (
   input  logic                         clock,
   input  b2da_pkg::cell_mode_type      mode,
   input  logic                         shift_carry,
   input  logic [3:0]                   shift_digit,
   output logic                         up_carry,
   output logic [3:0]                   cur_digit
);
   import b2da_pkg::*;

   logic [DIGIT_WIDTH-1:0] digit_ff;
   logic [DIGIT_WIDTH-1:0] digit_in;
   logic [DIGIT_WIDTH-1:0] adjusted;

   assign adjusted  = (digit_ff >= 4'd5) ? digit_ff + 4'd3 : digit_ff;
   assign up_carry  = adjusted[DIGIT_WIDTH-1];
   assign cur_digit = digit_ff;

   always_comb begin
      unique case (mode)
         MODE_HOLD:   digit_in = digit_ff;
         MODE_CLEAR:  digit_in = '0;
         MODE_DABBLE: digit_in = {adjusted[DIGIT_WIDTH-2:0], shift_carry};
         MODE_SHIFT:  digit_in = shift_digit;
         default:     digit_in = digit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

endmodule

### rtl/binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii: 64-bit unsigned binary to ASCII decimal digits
// Converts one value with a bit-serial double dabble over a row of twenty
// BCD digit cells, then streams the digits out most significant first,
// without leading zeros, marking the final digit.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   request   in         start / busy         req_value[63:0]
//   response  out        rsp_valid (strobe)   rsp_digit_char[5:0], rsp_last_digit
//
// A transaction is accepted on a rising edge with start high and busy low.
// Each value goes through a load step that takes the value and clears the
// row, 64 dabble steps (one input bit per cycle through the cell row), and
// 20 emit steps in which the digits shift up the row one digit per cycle and
// leave at the top. Each digit is registered on its way to the response ports.
// Reset is synchronous and clears the sequencer and the response strobe.
// The receiver cannot stall; each digit is on the ports for exactly one cycle.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_value,
   output logic        rsp_valid,
   output logic [5:0]  rsp_digit_char,
   output logic        rsp_last_digit
);
   import b2da_pkg::*;

   // Sequencer state.
   state_type                  state_ff, state_in;
   logic [CNT_WIDTH-1:0]       count_ff, count_in;
   logic                       seen_ff, seen_in;
   logic [VALUE_WIDTH-1:0]     value_ff, value_in;

   // Registered response.
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [CHAR_WIDTH-1:0]      rsp_char_ff, rsp_char_in;
   logic                       rsp_last_ff, rsp_last_in;

   // Cell row wiring.
   cell_mode_type              mode;
   logic                       carry_w [NUM_DIGITS];
   logic [DIGIT_WIDTH-1:0]     digit_w [NUM_DIGITS];
   logic [DIGIT_WIDTH-1:0]     top_digit;
   logic                       is_last;

   localparam logic [CNT_WIDTH-1:0] CONVERT_END = CNT_WIDTH'(VALUE_WIDTH - 1);
   localparam logic [CNT_WIDTH-1:0] EMIT_END    = CNT_WIDTH'(NUM_DIGITS - 1);

   // The row of digit cells. Cell zero takes the next input bit in dabble
   // mode and a zero digit in shift mode; every other cell is fed by the
   // cell below it.
   for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_row
      logic                   low_carry;
      logic [DIGIT_WIDTH-1:0] low_digit;
      if (i == 0) begin : g_bottom
         assign low_carry = value_ff[VALUE_WIDTH-1];
         assign low_digit = '0;
      end else begin : g_upper
         assign low_carry = carry_w[i-1];
         assign low_digit = digit_w[i-1];
      end
      b2da_cell u_digit (
         .clock       (clock),
         .mode        (mode),
         .shift_carry (low_carry),
         .shift_digit (low_digit),
         .up_carry    (carry_w[i]),
         .cur_digit   (digit_w[i])
      );
   end

   assign top_digit = digit_w[NUM_DIGITS-1];
   assign is_last   = (count_ff == EMIT_END);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      seen_in      = seen_ff;
      value_in     = value_ff;
      mode         = MODE_HOLD;
      rsp_valid_in = 1'b0;
      rsp_char_in  = ASCII_ZERO | CHAR_WIDTH'(top_digit);
      rsp_last_in  = is_last;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               value_in = req_value;
               count_in = '0;
               seen_in  = 1'b0;
               mode     = MODE_CLEAR;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            // One input bit enters the row per cycle, most significant first.
            mode     = MODE_DABBLE;
            value_in = {value_ff[VALUE_WIDTH-2:0], 1'b0};
            count_in = count_ff + CNT_WIDTH'(1);
            if (count_ff == CONVERT_END) begin
               count_in = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // The top digit leaves the row; leading zeros are dropped, but the
            // units digit always goes out so that zero gives a single '0'.
            mode         = MODE_SHIFT;
            rsp_valid_in = seen_ff || (top_digit != '0) || is_last;
            seen_in      = seen_ff || (top_digit != '0);
            count_in     = count_ff + CNT_WIDTH'(1);
            if (is_last) begin
               count_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff    <= value_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_last_digit = rsp_last_ff;

   // A digit strobe only follows a cycle of the emit phase.
   a_valid_from_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == ST_EMIT))
      else $error("response strobe outside the emit phase");

   // An accepted transaction starts the conversion.
   a_start_converts: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_CONVERT))
      else $error("accepted transaction did not start conversion");

   // The final emit cycle always delivers the marked units digit.
   a_last_delivered: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && is_last) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("units digit missing at end of run");

   // Nothing follows the marked digit of a run.
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |=> !rsp_valid_ff)
      else $error("digit after the final digit of a run");

endmodule

### verif/b2da_checker.sv
// ----------------------------------------------------------------------------
// b2da_checker: digit stream checker for the binary to decimal ASCII converter
// Watches accepted values, works out the decimal digits each one must
// produce and compares every response transaction with the oldest digit due.
// ----------------------------------------------------------------------------
module b2da_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  logic [b2da_pkg::VALUE_WIDTH-1:0] req_value,
   input  logic                             rsp_valid,
   input  logic [b2da_pkg::CHAR_WIDTH-1:0]  rsp_digit_char,
   input  logic                             rsp_last_digit,
   output int                               fail_count,
   output int                               pending_digits,
   output int                               value_count,
   output int                               digit_count
);
   import b2da_pkg::*;

   localparam int RADIX       = 10;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] digit_char;
      logic                  last_digit;
   } digit_type;

   digit_type digits_due[$];

   // Splits a value into decimal digits and queues them most significant first.
   function automatic void queue_decimal_digits(input logic [VALUE_WIDTH-1:0] value);
      logic [DIGIT_WIDTH-1:0] lsd_first[NUM_DIGITS];
      logic [VALUE_WIDTH-1:0] rest;
      digit_type              digit;
      int                     count;
      rest  = value;
      count = 0;
      do begin
         lsd_first[count] = DIGIT_WIDTH'(rest % RADIX);
         rest  = rest / RADIX;
         count++;
      end while (rest != 0 && count < NUM_DIGITS);
      for (int k = count - 1; k >= 0; k--) begin
         digit.digit_char = ASCII_ZERO + CHAR_WIDTH'(lsd_first[k]);
         digit.last_digit = (k == 0);
         digits_due.push_back(digit);
      end
   endfunction

   always @(posedge clock) begin
      digit_type due;
      int        fails;
      fails = fail_count;
      if (!reset) begin
         if (start && !busy) begin
            queue_decimal_digits(req_value);
            value_count <= value_count + 1;
         end
         if (rsp_valid) begin
            digit_count <= digit_count + 1;
            if (digits_due.size() == 0) begin
               fails++;
               if (fails <= REPORT_LIMIT)
                  $display("checker: unexpected digit char=%h last=%b",
                           rsp_digit_char, rsp_last_digit);
            end else begin
               due = digits_due.pop_front();
               if (rsp_digit_char !== due.digit_char ||
                   rsp_last_digit !== due.last_digit) begin
                  fails++;
                  if (fails <= REPORT_LIMIT)
                     $display({"checker: digit mismatch char exp=%h act=%h",
                               " last exp=%b act=%b"},
                              due.digit_char, rsp_digit_char, due.last_digit,
                              rsp_last_digit);
               end
            end
         end
      end
      fail_count     <= fails;
      pending_digits <= digits_due.size();
   end

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the binary to decimal ASCII converter
// Feeds directed corner values and then random values of every length to the
// converter under several sender idle patterns, while a checker compares the
// digit stream against its own decimal conversion.
// ----------------------------------------------------------------------------
module tb_top;
   import b2da_pkg::*;

   // Longest quiet stretch is one conversion plus the longest sender gap; the
   // limit leaves plenty of margin on top.
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = 100;
   localparam int ITEMS_PER_PHASE = 25;
   localparam int NUM_PHASES      = 4;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [VALUE_WIDTH-1:0] req_value;
   logic                   rsp_valid;
   logic [CHAR_WIDTH-1:0]  rsp_digit_char;
   logic                   rsp_last_digit;

   int fail_count;
   int pending_digits;
   int value_count;
   int digit_count;
   int quiet_cycles;

   binary_to_decimal_ascii u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit)
   );

   b2da_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit),
      .fail_count     (fail_count),
      .pending_digits (pending_digits),
      .value_count    (value_count),
      .digit_count    (digit_count)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // The watchdog counts cycles in which neither a value is taken nor a digit
   // comes out. A hung converter or a lost digit ends the run here.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Presents one value and holds it until the converter takes it. On return
   // the transaction has just been accepted and start is still high, so the
   // caller either raises the next value at once or lowers start.
   task automatic send_value(input logic [VALUE_WIDTH-1:0] value);
      start     <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (busy);
   endtask

   // Stops sending and waits until every digit due has come out. The first
   // edge lets the checker register the transaction that was just accepted.
   task automatic wait_for_digits;
      start <= 1'b0;
      do @(posedge clock); while (pending_digits != 0);
   endtask

   // Random values of random length, so that every digit count from one to
   // twenty turns up; the top bits are exercised less often than the low ones.
   function automatic logic [VALUE_WIDTH-1:0] random_value;
      logic [VALUE_WIDTH-1:0] raw;
      raw = {$urandom, $urandom};
      return raw >> $urandom_range(0, VALUE_WIDTH - 1);
   endfunction

   initial begin
      logic [VALUE_WIDTH-1:0] corner_values[$];
      int                     idle_percent[NUM_PHASES];
      reset        = 1'b1;
      start        = 1'b0;
      req_value    = '0;

      // Zero gives the single '0' digit. All ones is the longest run of
      // twenty digits. The rest sit on digit-count boundaries, on the top
      // bit, and carry inner zeros and every digit value.
      corner_values = '{
         64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100,
         64'd4294967295, 64'd4294967296,
         64'd1000000000000000000, 64'd1000000000000000001,
         64'd9999999999999999999, 64'd10000000000000000000,
         64'd12345678901234567890, 64'h7FFF_FFFF_FFFF_FFFF,
         64'h8000_0000_0000_0000, 64'hAAAA_AAAA_AAAA_AAAA,
         64'h5555_5555_5555_5555, 64'd18446744073709551610,
         64'hFFFF_FFFF_FFFF_FFFF
      };

      // Sender idle share per phase: none, heavy, light, none again. The
      // receiver cannot hold digits off, so only the sender side is varied.
      idle_percent = '{0, 64, 24, 0};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // The directed values go in back to back.
      foreach (corner_values[i])
         send_value(corner_values[i]);

      // Let the converter drain completely before the random phases, so the
      // next value arrives at an idle block.
      wait_for_digits();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         for (int item = 0; item < ITEMS_PER_PHASE; item++) begin
            send_value(random_value());
            // A gap of up to one conversion and more lets the next value land
            // at any point of the load, dabble and emit stages.
            if ($urandom_range(0, 99) < idle_percent[phase]) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 100)) @(posedge clock);
            end
         end
      end

      wait_for_digits();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Converted %0d values into %0d ASCII digits, from zero to all ones,",
               value_count, digit_count);
      $display("with back-to-back requests and sender gaps of up to 100 cycles.");
      if (fail_count == 0 && pending_digits == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
